// ===== src/nrm_pkg.sv =====
// Shared types and constants for the vector normalizer.
package nrm_pkg;

  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned DIV_STAGES  = 31;
  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned PIPE_DEPTH  = FRONT_STAGES + SQRT_STAGES + DIV_STAGES;

  typedef struct packed {
    logic signed [31:0] rod_x;
    logic signed [31:0] rod_y;
    logic signed [31:0] rod_z;
    logic               last_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic        [31:0] vec_length;
    logic               zero_length;
    logic               last_out;
  } out_t;

  // sideband that rides along the root pipeline
  typedef struct packed {
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic [31:0] mag_z;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
    logic        zero;
    logic        last;
  } side_t;

  // sideband that rides alongside the divider lanes
  typedef struct packed {
    logic [31:0] len;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
    logic        zero;
    logic        last;
  } dly_t;

endpackage

// ===== src/vector3_normalize_with_length_unit.sv =====
// Top level of the vector normalizer: squares, root, divider lanes and merge.
//
// Takes one signed 3-vector per item and returns its length floor(sqrt(x^2+y^2+z^2))
// in the input's Q format and the unit axis in signed Q2.30, truncated toward zero.
// A zero vector returns zero axis and length with zero_length set. A new item is
// accepted every clock while the output register is empty or being taken; each
// item passes three front stages (magnitude, three square lanes, sum), 32 root
// stages (one root bit per stage) and 31 divider stages (one quotient bit per
// stage, three lanes side by side), then the output register. The whole pipeline
// advances together and holds when the output register is full and not taken.
module vector3_normalize_with_length_unit import nrm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic adv;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic out_valid_r;
  out_t out_data_r;

  // advance whenever the output register is empty or being taken
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PIPE_DEPTH-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  // stage 1: magnitudes, signs and the zero-vector flag
  side_t s1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.mag_x <= in_data.rod_x[31] ? 32'(~in_data.rod_x + 32'sd1) : in_data.rod_x;
      s1_r.mag_y <= in_data.rod_y[31] ? 32'(~in_data.rod_y + 32'sd1) : in_data.rod_y;
      s1_r.mag_z <= in_data.rod_z[31] ? 32'(~in_data.rod_z + 32'sd1) : in_data.rod_z;
      s1_r.neg_x <= in_data.rod_x[31];
      s1_r.neg_y <= in_data.rod_y[31];
      s1_r.neg_z <= in_data.rod_z[31];
      s1_r.zero  <= (in_data.rod_x == '0) && (in_data.rod_y == '0) && (in_data.rod_z == '0);
      s1_r.last  <= in_data.last_in;
    end
  end

  // stage 2: one square per lane
  logic [63:0] sq_x_r, sq_y_r, sq_z_r;
  side_t s2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_x_r <= s1_r.mag_x * s1_r.mag_x;
      sq_y_r <= s1_r.mag_y * s1_r.mag_y;
      sq_z_r <= s1_r.mag_z * s1_r.mag_z;
      s2_r   <= s1_r;
    end
  end

  // stage 3: sum of squares, never overflows 64 bits
  logic [63:0] sum_r;
  side_t s3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sq_x_r + sq_y_r + sq_z_r;
      s3_r  <= s2_r;
    end
  end

  logic [31:0] root;
  side_t root_side;

  nrm_sqrt u_sqrt (
    .clk    (clk),
    .en     (adv),
    .n_i    (sum_r),
    .side_i (s3_r),
    .root_o (root),
    .side_o (root_side)
  );

  // three divider lanes share the length
  logic [30:0] quo_x, quo_y, quo_z;

  nrm_div_lane u_div_x (
    .clk(clk), .en(adv), .mag_i(root_side.mag_x), .len_i(root), .quo_o(quo_x)
  );
  nrm_div_lane u_div_y (
    .clk(clk), .en(adv), .mag_i(root_side.mag_y), .len_i(root), .quo_o(quo_y)
  );
  nrm_div_lane u_div_z (
    .clk(clk), .en(adv), .mag_i(root_side.mag_z), .len_i(root), .quo_o(quo_z)
  );

  // carry length, signs and flags beside the lanes
  dly_t dly_r [DIV_STAGES];
  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0].len   <= root;
      dly_r[0].neg_x <= root_side.neg_x;
      dly_r[0].neg_y <= root_side.neg_y;
      dly_r[0].neg_z <= root_side.neg_z;
      dly_r[0].zero  <= root_side.zero;
      dly_r[0].last  <= root_side.last;
      for (int j = 1; j < DIV_STAGES; j++) begin
        dly_r[j] <= dly_r[j-1];
      end
    end
  end

  // merge: apply signs, force zero vector results
  dly_t tail;
  out_t out_data_nxt;
  assign tail = dly_r[DIV_STAGES-1];

  always_comb begin
    out_data_nxt.axis_x      = tail.neg_x ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
    out_data_nxt.axis_y      = tail.neg_y ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});
    out_data_nxt.axis_z      = tail.neg_z ? -$signed({1'b0, quo_z}) : $signed({1'b0, quo_z});
    out_data_nxt.vec_length  = tail.len;
    out_data_nxt.zero_length = tail.zero;
    out_data_nxt.last_out    = tail.last;
    if (tail.zero) begin
      out_data_nxt.axis_x     = '0;
      out_data_nxt.axis_y     = '0;
      out_data_nxt.axis_z     = '0;
      out_data_nxt.vec_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a zero vector never shows a length or an x or y axis component
  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_length |->
      out_data.vec_length == '0 && out_data.axis_x == '0 && out_data.axis_y == '0)
    else $error("zero vector with nonzero result");

  // a nonzero vector has a length of at least one
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.zero_length |-> out_data.vec_length != '0)
    else $error("nonzero vector with zero length");

  // the x axis component stays within plus or minus one
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.axis_x <= 32'sh4000_0000) && (out_data.axis_x >= -32'sh4000_0000))
    else $error("axis_x out of range");

endmodule

// ===== src/nrm_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module nrm_sqrt import nrm_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n_i,
  input  side_t       side_i,
  output logic [31:0] root_o,
  output side_t       side_o
);

  logic [63:0] n_r    [SQRT_STAGES];
  logic [33:0] rem_r  [SQRT_STAGES];
  logic [31:0] root_r [SQRT_STAGES];
  side_t       side_r [SQRT_STAGES];

  genvar i;
  generate
    for (i = 0; i < SQRT_STAGES; i++) begin : g_stage
      logic [63:0] n_in;
      logic [33:0] rem_in;
      logic [31:0] root_in;
      side_t       side_in;
      logic [35:0] rem2;
      logic [35:0] trial;
      logic        take;

      if (i == 0) begin : g_first
        assign n_in    = n_i;
        assign rem_in  = '0;
        assign root_in = '0;
        assign side_in = side_i;
      end else begin : g_next
        assign n_in    = n_r[i-1];
        assign rem_in  = rem_r[i-1];
        assign root_in = root_r[i-1];
        assign side_in = side_r[i-1];
      end

      // bring down the next two radicand bits and try root*4+1
      assign rem2  = {rem_in, n_in[63-2*i -: 2]};
      assign trial = {2'b00, root_in, 2'b01};
      assign take  = (rem2 >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          n_r[i]    <= n_in;
          side_r[i] <= side_in;
          if (take) begin
            rem_r[i] <= 34'(rem2 - trial);
          end else begin
            rem_r[i] <= rem2[33:0];
          end
          root_r[i] <= {root_in[30:0], take};
        end
      end
    end
  endgenerate

  assign root_o = root_r[SQRT_STAGES-1];
  assign side_o = side_r[SQRT_STAGES-1];

endmodule

// ===== src/nrm_div_lane.sv =====
// One divider lane: (mag << 30) / len, one quotient bit per stage, mag <= len.
module nrm_div_lane import nrm_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] mag_i,
  input  logic [31:0] len_i,
  output logic [30:0] quo_o
);

  logic [32:0] rem_r [DIV_STAGES];
  logic [31:0] len_r [DIV_STAGES];
  logic [30:0] quo_r [DIV_STAGES];

  genvar k;
  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [32:0] rem_in;
      logic [31:0] len_in;
      logic [30:0] quo_in;
      logic        ge;
      logic [32:0] rs;

      if (k == 0) begin : g_first
        assign rem_in = {1'b0, mag_i};
        assign len_in = len_i;
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign len_in = len_r[k-1];
        assign quo_in = quo_r[k-1];
      end

      assign ge = (rem_in >= {1'b0, len_in});
      assign rs = ge ? (rem_in - {1'b0, len_in}) : rem_in;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= {rs[31:0], 1'b0};
          len_r[k] <= len_in;
          quo_r[k] <= {quo_in[29:0], ge};
        end
      end
    end
  endgenerate

  assign quo_o = quo_r[DIV_STAGES-1];

endmodule

// ===== tb/sv/nrm_checker.sv =====
// Checker for the vector normalizer: predicts each result and compares it.
module nrm_checker import nrm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending
);

  out_t expected_q[$];

  function automatic logic [31:0] root_floor(logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem = n;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[31:0];
  endfunction

  function automatic logic [31:0] unit_part(logic signed [31:0] v, logic [31:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    q = (mag << 30) / {32'd0, len};
    if (v[31]) q = -q;
    return q[31:0];
  endfunction

  function automatic out_t normalize(in_t d);
    out_t r;
    logic [63:0] mx, my, mz, sum;
    mx = d.rod_x[31] ? (64'h1_0000_0000 - {32'd0, d.rod_x}) : {32'd0, d.rod_x};
    my = d.rod_y[31] ? (64'h1_0000_0000 - {32'd0, d.rod_y}) : {32'd0, d.rod_y};
    mz = d.rod_z[31] ? (64'h1_0000_0000 - {32'd0, d.rod_z}) : {32'd0, d.rod_z};
    sum = mx * mx + my * my + mz * mz;
    r = '0;
    r.last_out = d.last_in;
    if (sum == 0) begin
      r.zero_length = 1'b1;
    end else begin
      r.vec_length = root_floor(sum);
      r.axis_x = unit_part(d.rod_x, r.vec_length);
      r.axis_y = unit_part(d.rod_y, r.vec_length);
      r.axis_z = unit_part(d.rod_z, r.vec_length);
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_t e;
    if (rst_n) begin
      if (in_valid && in_ready) expected_q = {expected_q, normalize(in_data)};
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected item", out_data.vec_length, 32'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_data.axis_x !== e.axis_x) report("axis_x", out_data.axis_x, e.axis_x);
          if (out_data.axis_y !== e.axis_y) report("axis_y", out_data.axis_y, e.axis_y);
          if (out_data.axis_z !== e.axis_z) report("axis_z", out_data.axis_z, e.axis_z);
          if (out_data.vec_length !== e.vec_length)
            report("vec_length", out_data.vec_length, e.vec_length);
          if (out_data.zero_length !== e.zero_length)
            report("zero_length", out_data.zero_length, e.zero_length);
          if (out_data.last_out !== e.last_out)
            report("last_out", out_data.last_out, e.last_out);
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ===== tb/sv/tb_vector3_normalize_with_length_unit.sv =====
// Testbench top for the vector normalizer: stimulus, stalls and verdict.
module tb_vector3_normalize_with_length_unit import nrm_pkg::*; ();

  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_VECTORS = 1250;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;

  in_t  vec_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vector3_normalize_with_length_unit uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  nrm_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  // Pick a component: half the time full-range, sometimes tiny, 16-bit or extreme.
  function automatic logic [31:0] pick_component();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(0, 8) - 4;
      4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t make_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                   logic lst);
    in_t v;
    v.rod_x = x;
    v.rod_y = y;
    v.rod_z = z;
    v.last_in = lst;
    return v;
  endfunction

  // Receiver: stall on its own pattern, alternating calm and busy stretches.
  always @(posedge clk) begin
    int phase;
    phase = int'(($time / 10) % 600);
    if (phase < 150) out_ready <= 1'b1;
    else if (phase < 300) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 2) == 0);
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int burst;
    int gap;
    int settle;
    // Directed vectors: extremes, zero, unit axes, tiny values, sign mixes.
    vec_q = {vec_q, make_vec(0, 0, 0, 1'b0)};
    vec_q = {vec_q, make_vec(0, 0, 0, 1'b1)};
    vec_q = {vec_q, make_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1)};
    vec_q = {vec_q, make_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0)};
    vec_q = {vec_q, make_vec(32'h8000_0000, 0, 0, 1'b0)};
    vec_q = {vec_q, make_vec(0, 32'h7fff_ffff, 0, 1'b0)};
    vec_q = {vec_q, make_vec(0, 0, 32'hffff_ffff, 1'b0)};
    vec_q = {vec_q, make_vec(1, 0, 0, 1'b0)};
    vec_q = {vec_q, make_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1)};
    vec_q = {vec_q, make_vec(32'h0001_0000, 0, 0, 1'b0)};
    vec_q = {vec_q, make_vec(0, 32'hffff_0000, 0, 1'b0)};
    vec_q = {vec_q, make_vec(3, 4, 0, 1'b0)};
    vec_q = {vec_q, make_vec(32'h7fff_ffff, 32'h8000_0000, 1, 1'b1)};
    vec_q = {vec_q, make_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 1'b0)};
    for (int i = 0; i < RANDOM_VECTORS; i++)
      vec_q = {vec_q, make_vec(pick_component(), pick_component(), pick_component(),
                               $urandom_range(0, 7) == 0)};

    // Hold reset, then release.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Send in bursts with random gaps; keep valid steady until accepted.
    while (vec_q.size() > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      for (int k = 0; k < burst && vec_q.size() > 0; k++) begin
        in_valid <= 1'b1;
        in_data <= vec_q.pop_front();
        @(posedge clk);
        while (!in_ready) @(posedge clk);
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_data <= make_vec($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // Drain, then let any straggler surface.
    while (pending > 0) @(posedge clk);
    settle = 0;
    while (settle < 2 * PIPE_DEPTH) begin
      @(posedge clk);
      settle++;
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
